### hw/rtl/tkmdd_pkg.sv
// Package with the item types and constants of the touch key matrix detector.
package tkmdd_pkg;

    localparam int ROW_COUNT    = 8;
    localparam int COLUMN_COUNT = 8;
    localparam int KEY_COUNT    = ROW_COUNT * COLUMN_COUNT;

    localparam int ROW_W     = 3;
    localparam int COL_W     = 3;
    localparam int SAMPLE_W  = 8;
    localparam int THR_SHIFT = 3;

    localparam int LIM_W     = 5;
    localparam int COL_IDX_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam int KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int KEY_ENT_W = 2;

    typedef struct packed {
        logic [ROW_W-1:0]    key_row;
        logic [COL_W-1:0]    key_column;
        logic [SAMPLE_W-1:0] sample;
        logic                last_in_scan;
    } t_in_item;

    typedef struct packed {
        logic key_pressed;
        logic key_changed;
        logic scan_changed;
        logic calibrated_now;
    } t_out_item;

    typedef struct packed {
        logic pending;
        logic stable;
    } t_key_ent;

endpackage

### hw/rtl/tkmdd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module tkmdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/touch_key_matrix_detect_debounce.sv
// Top level of the touch key matrix detector with per-column calibration and debounce.
//
//   port group      direction  handshake                     payload
//   input items     in         i_in_valid / o_in_ready       i_in_item  (t_in_item)
//   result items    out        o_out_valid / i_out_ready     o_out_item (t_out_item)
//
// One item per cycle is sustained while results are taken. An item reads the threshold
// and key RAMs in the cycle it is accepted, is evaluated and written back when it
// leaves the evaluation stage, and its result is then held in the output register.
// Reset clears all valid bits at once, so the block accepts items right after reset.
// While the output register is full and not taken, the evaluation stage holds and
// input ready drops once both stages are full.
module touch_key_matrix_detect_debounce
    import tkmdd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic                 in_acc;
    logic                 in_rng;
    logic [COL_IDX_W-1:0] in_col;
    logic [KEY_IDX_W-1:0] in_idx;

    logic                 r_s1_vld;
    t_in_item             r_s1_item;
    logic                 r_s1_rng;
    logic [COL_IDX_W-1:0] r_s1_col;
    logic [KEY_IDX_W-1:0] r_s1_idx;
    logic                 r_s1_thr_vld;
    logic                 r_s1_key_vld;
    logic                 r_fwd_thr_hit;
    logic [SAMPLE_W-1:0]  r_fwd_thr;
    logic                 r_fwd_key_hit;
    t_key_ent             r_fwd_key;

    logic [COLUMN_COUNT-1:0] r_thr_vld;
    logic [KEY_COUNT-1:0]    r_key_vld;
    logic                    r_scan_acc;
    logic                    r_out_vld;
    t_out_item               r_out;

    logic [SAMPLE_W-1:0]  thr_rd;
    logic [KEY_ENT_W-1:0] key_rd;
    logic [SAMPLE_W-1:0]  thr;
    t_key_ent             key_cur;
    t_key_ent             key_new;
    logic [SAMPLE_W-1:0]  thr_new;
    logic                 s1_adv;
    logic                 thr_wr;
    logic                 key_wr;
    logic                 raw;
    logic                 chg;
    logic                 calib;
    logic                 acc_now;
    t_out_item            n_out;

    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    assign in_rng = (LIM_W'(i_in_item.key_row) < LIM_W'(ROW_COUNT))
                 && (LIM_W'(i_in_item.key_column) < LIM_W'(COLUMN_COUNT));
    assign in_col = COL_IDX_W'(i_in_item.key_column);
    assign in_idx = KEY_IDX_W'(KEY_IDX_W'(i_in_item.key_row) * KEY_IDX_W'(COLUMN_COUNT)
                             + KEY_IDX_W'(i_in_item.key_column));

    tkmdd_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(COLUMN_COUNT)
    ) u_thr_ram (
        .i_clk    (i_clk),
        .i_wr_en  (thr_wr),
        .i_wr_addr(r_s1_col),
        .i_wr_data(thr_new),
        .i_rd_en  (in_acc),
        .i_rd_addr(in_col),
        .o_rd_data(thr_rd)
    );

    tkmdd_ram #(
        .WIDTH(KEY_ENT_W),
        .DEPTH(KEY_COUNT)
    ) u_key_ram (
        .i_clk    (i_clk),
        .i_wr_en  (key_wr),
        .i_wr_addr(r_s1_idx),
        .i_wr_data(key_new),
        .i_rd_en  (in_acc),
        .i_rd_addr(in_idx),
        .o_rd_data(key_rd)
    );

    always_comb begin
        if (r_fwd_thr_hit) begin
            thr = r_fwd_thr;
        end else if (r_s1_thr_vld) begin
            thr = thr_rd;
        end else begin
            thr = '0;
        end

        if (r_fwd_key_hit) begin
            key_cur = r_fwd_key;
        end else if (r_s1_key_vld) begin
            key_cur = t_key_ent'(key_rd);
        end else begin
            key_cur = '0;
        end

        thr_new = r_s1_item.sample - (r_s1_item.sample >> THR_SHIFT);
        raw     = r_s1_item.sample < thr;
        calib   = r_s1_rng && (thr == '0);
        chg     = 1'b0;
        key_new = key_cur;
        if (raw != key_cur.stable) begin
            if (!key_cur.pending) begin
                key_new.pending = 1'b1;
            end else begin
                key_new.pending = 1'b0;
                key_new.stable  = !key_cur.stable;
                chg             = r_s1_rng;
            end
        end else begin
            key_new.pending = 1'b0;
        end

        thr_wr  = s1_adv && calib;
        key_wr  = s1_adv && r_s1_rng;
        acc_now = r_scan_acc || chg;

        n_out.key_pressed    = r_s1_rng && key_new.stable;
        n_out.key_changed    = chg;
        n_out.scan_changed   = r_s1_item.last_in_scan && acc_now;
        n_out.calibrated_now = calib;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld      <= 1'b0;
            r_fwd_thr_hit <= 1'b0;
            r_fwd_key_hit <= 1'b0;
            r_thr_vld     <= '0;
            r_key_vld     <= '0;
            r_scan_acc    <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld      <= 1'b1;
                r_s1_thr_vld  <= r_thr_vld[in_col];
                r_s1_key_vld  <= r_key_vld[in_idx];
                r_fwd_thr_hit <= thr_wr && (r_s1_col == in_col);
                r_fwd_key_hit <= key_wr && (r_s1_idx == in_idx);
            end else if (s1_adv) begin
                r_s1_vld      <= 1'b0;
                r_fwd_thr_hit <= 1'b0;
                r_fwd_key_hit <= 1'b0;
            end

            if (thr_wr) begin
                r_thr_vld[r_s1_col] <= 1'b1;
            end
            if (key_wr) begin
                r_key_vld[r_s1_idx] <= 1'b1;
            end

            if (s1_adv) begin
                r_scan_acc <= acc_now && !r_s1_item.last_in_scan;
                r_out_vld  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in_item;
            r_s1_rng  <= in_rng;
            r_s1_col  <= in_col;
            r_s1_idx  <= in_idx;
            r_fwd_thr <= thr_new;
            r_fwd_key <= key_new;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_vld && r_out_vld))
        else $error("input stalled while a stage was free");

    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fwd_thr_hit || r_fwd_key_hit) |-> r_s1_vld)
        else $error("forwarding active without an item in evaluation");

    a_scan_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_item.last_in_scan) |=> !r_scan_acc)
        else $error("scan change flag not cleared after the last item of a scan");

endmodule
